>>> src/srtq_pkg.sv
// Shared types and codes for the sorted ready-time queue.
// Used by the channel interfaces and by the queue top level.
package srtq_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [1:0]  status_t;
  typedef logic [15:0] id_t;
  typedef logic [15:0] minutes_t;
  typedef logic [4:0]  count5_t;

  // item kinds
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_POP    = 2'd1;
  localparam kind_t KIND_COUNT  = 2'd2;

  // result status codes
  localparam status_t STATUS_OK   = 2'd0;
  localparam status_t STATUS_FULL = 2'd1;
  localparam status_t STATUS_NONE = 2'd2;

  // one stored slot
  typedef struct packed {
    id_t      id;
    minutes_t minutes;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_LAST,
    ST_POP,
    ST_CNT
  } state_t;

endpackage

>>> src/srtq_in_if.sv
// Input channel of the sorted ready-time queue: valid/ready plus item payload.
// Depends on srtq_pkg.
interface srtq_in_if;
  import srtq_pkg::*;

  logic     valid;
  logic     ready;
  kind_t    kind;
  id_t      entry_id;
  minutes_t entry_minutes;

  modport source (output valid, output kind, output entry_id, output entry_minutes,
                  input ready);
  modport sink   (input valid, input kind, input entry_id, input entry_minutes,
                  output ready);
endinterface

>>> src/srtq_out_if.sv
// Result channel of the sorted ready-time queue: valid/ready plus result payload.
// Depends on srtq_pkg.
interface srtq_out_if;
  import srtq_pkg::*;

  logic     valid;
  logic     ready;
  status_t  status;
  id_t      popped_id;
  minutes_t popped_minutes;
  count5_t  match_count;
  count5_t  ready_count;
  count5_t  occupancy;
  logic     is_empty;
  logic     is_full;

  modport source (output valid, output status, output popped_id, output popped_minutes,
                  output match_count, output ready_count, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input popped_id, input popped_minutes,
                  input match_count, input ready_count, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

>>> src/sorted_ready_time_queue.sv
// Sorted ready-time queue top level: one slot memory, a circular head pointer
// and a sequencer for insert, pop and id count. Depends on srtq_pkg,
// srtq_in_if and srtq_out_if.
//
// Usage:
//   in_chan carries items (kind, entry_id, entry_minutes); out_chan returns
//   exactly one result item per input item, in order. Entries stay sorted by
//   minutes, equal keys in arrival order; a pop takes the head only if its
//   minutes are zero.
// Sequencing (one item in flight at a time):
//   pop of a ready head     reads the head from the slot memory, then returns it
//   insert                  shifts every stored entry with larger minutes up by
//                           one slot, one shift per cycle, then writes the new entry
//   count                   reads the stored slots in order, one slot read per cycle
//   insert into an empty or a full queue, pop with nothing ready, count of an
//   empty queue and unused kinds finish in the idle state without a scan.
//   The slot memory has one write port and one registered read port.
// Reset: synchronous, active low; the queue comes up empty, no sweep needed.
// Stall: results sit in an output register; a new item is taken while a
//   finished result is being handed off, and the sequencer holds its last
//   step while the output register is still full.
module sorted_ready_time_queue #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  srtq_in_if.sink    in_chan,
  srtq_out_if.source out_chan
);
  import srtq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // slot memory and its read register
  entry_t slot_mem [DEPTH];
  entry_t rd_data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ready_r, ready_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] match_r, match_nxt;
  id_t           key_id_r, key_id_nxt;
  minutes_t      key_min_r, key_min_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  id_t           out_pid_r;
  minutes_t      out_pmin_r;
  count5_t       out_match_r;
  count5_t       out_ready_r;
  count5_t       out_occ_r;
  logic          out_empty_r;
  logic          out_full_r;

  logic          res_load;
  status_t       res_status;
  id_t           res_pid;
  minutes_t      res_pmin;
  logic [CW-1:0] res_match;
  logic          out_free;
  logic          in_fire;
  logic [CW-1:0] match_sum;
  logic [31:0]   occ_wide, ready_wide, match_wide;

  // logical position to memory address, relative to the head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] lpos);
    logic [AW:0] sum;
    sum = (AW+1)'(head) + (AW+1)'(lpos);
    if (sum >= (AW+1)'(DEPTH)) sum = sum - (AW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign out_free = !out_valid_r || out_chan.ready;
  // a new item is taken only by an idle sequencer with room for its result
  assign in_chan.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign match_sum = match_r + CW'(rd_data_r.id == key_id_r);

  // sequencer: next state, memory accesses and result capture
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    ready_nxt   = ready_r;
    pos_nxt     = pos_r;
    match_nxt   = match_r;
    key_id_nxt  = key_id_r;
    key_min_nxt = key_min_r;
    mem_we      = 1'b0;
    mem_waddr   = phys(head_r, pos_r);
    mem_wdata   = '{id: key_id_r, minutes: key_min_r};
    mem_re      = 1'b0;
    mem_raddr   = head_r;
    res_load    = 1'b0;
    res_status  = STATUS_OK;
    res_pid     = '0;
    res_pmin    = '0;
    res_match   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_id_nxt  = in_chan.entry_id;
          key_min_nxt = in_chan.entry_minutes;
          unique case (in_chan.kind)
            KIND_INSERT: begin
              if (count_r == CW'(DEPTH)) begin
                res_load   = 1'b1;
                res_status = STATUS_FULL;
              end else if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = head_r;
                mem_wdata = '{id: in_chan.entry_id, minutes: in_chan.entry_minutes};
                count_nxt = count_r + CW'(1);
                ready_nxt = ready_r + CW'(in_chan.entry_minutes == '0);
                res_load  = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = phys(head_r, count_r - CW'(1));
                pos_nxt   = count_r;
                state_nxt = ST_INS;
              end
            end
            KIND_POP: begin
              // head is ready exactly when some leading entry has zero minutes
              if (ready_r == '0) begin
                res_load   = 1'b1;
                res_status = STATUS_NONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = ST_POP;
              end
            end
            KIND_COUNT: begin
              if (count_r == '0) begin
                res_load = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                pos_nxt   = '0;
                match_nxt = '0;
                state_nxt = ST_CNT;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      ST_INS: begin
        // rd_data_r holds the entry at pos_r - 1
        if (rd_data_r.minutes > key_min_r) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data_r;
          pos_nxt   = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = ST_INS_LAST;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = phys(head_r, pos_r - CW'(2));
          end
        end else if (out_free) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          ready_nxt = ready_r + CW'(key_min_r == '0);
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_INS_LAST: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = head_r;
          count_nxt = count_r + CW'(1);
          ready_nxt = ready_r + CW'(key_min_r == '0);
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_POP: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_pid   = rd_data_r.id;
          res_pmin  = rd_data_r.minutes;
          head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          ready_nxt = ready_r - CW'(1);
          state_nxt = ST_IDLE;
        end
      end

      ST_CNT: begin
        // rd_data_r holds the entry at pos_r
        if (pos_r == count_r - CW'(1)) begin
          if (out_free) begin
            res_load  = 1'b1;
            res_match = match_sum;
            state_nxt = ST_IDLE;
          end
        end else begin
          match_nxt = match_sum;
          pos_nxt   = pos_r + CW'(1);
          mem_re    = 1'b1;
          mem_raddr = phys(head_r, pos_r + CW'(1));
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= slot_mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ready_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operands and scan state
  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    match_r   <= match_nxt;
    key_id_r  <= key_id_nxt;
    key_min_r <= key_min_nxt;
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load)            out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  // count fields are reported modulo 32
  assign occ_wide   = 32'(count_nxt);
  assign ready_wide = 32'(ready_nxt);
  assign match_wide = 32'(res_match);

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_pid_r    <= res_pid;
      out_pmin_r   <= res_pmin;
      out_match_r  <= match_wide[4:0];
      out_ready_r  <= ready_wide[4:0];
      out_occ_r    <= occ_wide[4:0];
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == CW'(DEPTH));
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.popped_id      = out_pid_r;
  assign out_chan.popped_minutes = out_pmin_r;
  assign out_chan.match_count    = out_match_r;
  assign out_chan.ready_count    = out_ready_r;
  assign out_chan.occupancy      = out_occ_r;
  assign out_chan.is_empty       = out_empty_r;
  assign out_chan.is_full        = out_full_r;

  // checks
  a_ready_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r <= count_r)
    else $error("ready entries exceed stored entries");

  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_FULL) |-> out_full_r)
    else $error("full rejection reported on a queue that is not full");

  a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_POP) |=> $stable(head_r))
    else $error("head moved outside a pop");

endmodule

>>> dv/srtq_result_check.sv
// Result checker for the sorted ready-time queue: mirrors the sorted slot list,
// predicts one result per accepted item and compares it with the result channel.
// Depends on srtq_pkg, srtq_in_if and srtq_out_if.
module srtq_result_check #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  srtq_in_if   in_mon,
  srtq_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import srtq_pkg::*;

  typedef struct {
    status_t  status;
    id_t      popped_id;
    minutes_t popped_minutes;
    count5_t  match_count;
    count5_t  ready_count;
    count5_t  occupancy;
    logic     is_empty;
    logic     is_full;
  } result_t;

  // mirrored queue contents, sorted ascending by minutes
  id_t      slot_id  [DEPTH];
  minutes_t slot_min [DEPTH];
  int       stored = 0;
  int       fails = 0;

  result_t  awaited_results[$];

  // apply one item to the mirrored list and build its result
  function automatic result_t queue_step(kind_t kind, id_t id, minutes_t mins);
    result_t r;
    int      pos;
    int      n;
    r.status         = STATUS_OK;
    r.popped_id      = '0;
    r.popped_minutes = '0;
    r.match_count    = '0;
    case (kind)
      KIND_INSERT: begin
        if (stored >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          // equal keys stay ahead of the new entry
          pos = stored;
          while (pos > 0 && slot_min[pos-1] > mins) begin
            slot_id[pos]  = slot_id[pos-1];
            slot_min[pos] = slot_min[pos-1];
            pos--;
          end
          slot_id[pos]  = id;
          slot_min[pos] = mins;
          stored++;
        end
      end
      KIND_POP: begin
        if (stored == 0 || slot_min[0] != '0) begin
          r.status = STATUS_NONE;
        end else begin
          r.popped_id      = slot_id[0];
          r.popped_minutes = slot_min[0];
          for (int i = 0; i + 1 < stored; i++) begin
            slot_id[i]  = slot_id[i+1];
            slot_min[i] = slot_min[i+1];
          end
          stored--;
        end
      end
      KIND_COUNT: begin
        n = 0;
        for (int i = 0; i < stored; i++)
          if (slot_id[i] == id) n++;
        r.match_count = n[4:0];
      end
      default: ;
    endcase
    // summary fields reflect the list after the item
    n = 0;
    while (n < stored && slot_min[n] == '0) n++;
    r.ready_count = n[4:0];
    r.occupancy   = stored[4:0];
    r.is_empty    = (stored == 0);
    r.is_full     = (stored == DEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // results are compared before the item taken at the same edge is queued
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      stored = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result item with nothing awaited, status %0h occupancy %0d",
                   $time, out_mon.status, out_mon.occupancy);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status",         16'(want.status),         16'(out_mon.status));
          check_field("popped_id",      want.popped_id,           out_mon.popped_id);
          check_field("popped_minutes", want.popped_minutes,      out_mon.popped_minutes);
          check_field("match_count",    16'(want.match_count),    16'(out_mon.match_count));
          check_field("ready_count",    16'(want.ready_count),    16'(out_mon.ready_count));
          check_field("occupancy",      16'(want.occupancy),      16'(out_mon.occupancy));
          check_field("is_empty",       16'(want.is_empty),       16'(out_mon.is_empty));
          check_field("is_full",        16'(want.is_full),        16'(out_mon.is_full));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(queue_step(in_mon.kind, in_mon.entry_id,
                                             in_mon.entry_minutes));
    end
    pending    <= awaited_results.size();
    fail_count <= fails;
  end

endmodule

>>> dv/tb_sorted_ready_time_queue.sv
// Testbench top for the sorted ready-time queue: clock, reset, item stimulus,
// result-side stalls and the verdict. Depends on srtq_pkg, the channel
// interfaces, sorted_ready_time_queue and srtq_result_check.
module tb_sorted_ready_time_queue;
  import srtq_pkg::*;

  localparam int    DEPTH         = 16;
  localparam int    RANDOM_ITEMS  = 2000;
  localparam int    PHASE_ITEMS   = 100;
  localparam int    PHASES        = RANDOM_ITEMS / PHASE_ITEMS;
  localparam int    NONZERO_CAP   = 10;   // nonzero keys never leave the list
  localparam int    HOLD_CYCLES   = 80;
  localparam int    SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int    CYCLE_LIMIT   = 400000;
  localparam kind_t KIND_UNUSED   = 2'd3;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk;
  logic rst_n;
  logic idle_en;
  logic long_hold;
  logic hold_taken;
  int   hold_left;
  int   stall_left;
  int   nonzero_left;
  int   fail_count;
  int   pending;

  srtq_in_if  in_chan ();
  srtq_out_if out_chan ();

  sorted_ready_time_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  srtq_result_check #(.DEPTH(DEPTH)) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // result side: one long hold-off on request, otherwise short random stalls
  initial begin
    hold_taken = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (long_hold && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // offer one item, maybe after a short gap, and wait for it to be taken
  task automatic send(input kind_t k, input id_t id, input minutes_t mins);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.kind          <= k;
    in_chan.entry_id      <= id;
    in_chan.entry_minutes <= mins;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // stop offering until every awaited result has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly ready (zero-minute) inserts and pops; nonzero keys are rationed
  task automatic send_random(input mix_t mix);
    int       roll;
    int       ins_pct;
    int       pop_pct;
    kind_t    k;
    id_t      id;
    minutes_t mins;
    ins_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 25 : 45;
    pop_pct = (mix == MIX_FILL) ? 20 : (mix == MIX_DRAIN) ? 60 : 35;
    roll    = $urandom_range(0, 99);
    // a small id pool makes count queries hit
    id      = ($urandom_range(0, 1) == 1) ? id_t'($urandom_range(0, 7)) : id_t'($urandom());
    mins    = minutes_t'($urandom());
    if (roll < ins_pct) begin
      k = KIND_INSERT;
      if (nonzero_left > 0 && $urandom_range(0, 39) == 0) begin
        nonzero_left--;
        case ($urandom_range(0, 2))
          0:       mins = minutes_t'($urandom_range(1, 3));
          1:       mins = 16'hFFFF;
          default: mins = minutes_t'($urandom_range(1, 65535));
        endcase
      end else begin
        mins = '0;
      end
    end else if (roll < ins_pct + pop_pct) begin
      k = KIND_POP;
    end else if (roll < 96) begin
      k = KIND_COUNT;
    end else begin
      k = KIND_UNUSED;
    end
    send(k, id, mins);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    idle_en               <= 1'b1;
    long_hold             <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.kind          <= KIND_INSERT;
    in_chan.entry_id      <= '0;
    in_chan.entry_minutes <= '0;
    nonzero_left = NONZERO_CAP;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: pop, count and the unused kind
    send(KIND_POP,    16'h0000, 16'hFFFF);
    send(KIND_COUNT,  16'hFFFF, 16'h0000);
    send(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    // two ready entries: every entry ready, then popped in arrival order
    send(KIND_INSERT, 16'h0000, 16'h0000);
    send(KIND_INSERT, 16'hFFFF, 16'h0000);
    send(KIND_POP,    16'h0000, 16'h0000);
    send(KIND_POP,    16'h0000, 16'h0000);
    // largest key at the head: nothing ready
    send(KIND_INSERT, 16'h1234, 16'hFFFF);
    send(KIND_POP,    16'hFFFF, 16'hFFFF);
    // fill with equal zero keys ahead of it, then insert into a full list
    for (int i = 0; i < DEPTH - 1; i++)
      send(KIND_INSERT, (i % 2 != 0) ? id_t'(16'hFFFF) : id_t'(16'h00AA), 16'h0000);
    send(KIND_INSERT, 16'h5555, 16'h8000);
    send(KIND_COUNT,  16'hFFFF, 16'h0000);

    // random phases; idling off in a few phases and in the last stretch
    for (int p = 0; p < PHASES; p++) begin
      idle_en <= (p < PHASES - 3) && (p != 4) && (p != 12);
      if (p == 4) long_hold <= 1'b1;
      if (p == 10) drain();
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random(mix_t'(p % 3));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
